/* design/tgad_pkg.sv */
// ---------------------------------------------------------------------------
// tgad_pkg
// Types and constants shared by the uncompressed TGA decoder modules.
// ---------------------------------------------------------------------------
`default_nettype none

package tgad_pkg;

	localparam int unsigned HDR_LEN = 18;
	localparam int unsigned HCNT_W  = 5;

	localparam logic [HCNT_W-1:0] HDR_IDX_ID_LEN = HCNT_W'(0);
	localparam logic [HCNT_W-1:0] HDR_IDX_TYPE   = HCNT_W'(2);
	localparam logic [HCNT_W-1:0] HDR_IDX_W_LO   = HCNT_W'(12);
	localparam logic [HCNT_W-1:0] HDR_IDX_W_HI   = HCNT_W'(13);
	localparam logic [HCNT_W-1:0] HDR_IDX_H_LO   = HCNT_W'(14);
	localparam logic [HCNT_W-1:0] HDR_IDX_H_HI   = HCNT_W'(15);
	localparam logic [HCNT_W-1:0] HDR_IDX_BPP    = HCNT_W'(16);
	localparam logic [HCNT_W-1:0] HDR_IDX_DESC   = HCNT_W'(HDR_LEN - 1);

	localparam logic [7:0] TYPE_TRUECOLOUR = 8'd2;
	localparam logic [7:0] TYPE_GREY       = 8'd3;
	localparam logic [7:0] BPP_24          = 8'd24;
	localparam logic [7:0] BPP_32          = 8'd32;
	localparam int unsigned DESC_TOP_FIRST_BIT = 5;
	localparam logic [7:0] OPAQUE          = 8'hFF;

	localparam logic [1:0] ST_PIXEL       = 2'd0;
	localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
	localparam logic [1:0] ST_EMPTY       = 2'd2;

	typedef struct packed {
		logic [7:0] file_byte;
		logic       start_of_file;
	} tgad_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] dest_row;
		logic [15:0] dest_col;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic        last_pixel;
	} tgad_out_t;

	typedef struct packed {
		logic      valid;
		tgad_out_t item;
	} tgad_res_t;

endpackage

`default_nettype wire

/* design/tgad_in_reg.sv */
// ---------------------------------------------------------------------------
// tgad_in_reg
// Input register: holds one file byte item until the parser takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module tgad_in_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              file_valid,
	output logic                   file_stall,
	input  wire tgad_pkg::tgad_in_t file_item,
	input  wire logic              adv,
	output logic                   valid_s1,
	output tgad_pkg::tgad_in_t     item_s1
);
	import tgad_pkg::*;

	assign file_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!file_stall) begin
			valid_s1 <= file_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (file_valid && !file_stall) begin
			item_s1 <= file_item;
		end
	end

endmodule

`default_nettype wire

/* design/tgad_core.sv */
// ---------------------------------------------------------------------------
// tgad_core
// Header parser, ID skip and pixel assembly; one byte consumed per advance.
// ---------------------------------------------------------------------------
`default_nettype none

module tgad_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               valid_s1,
	input  wire tgad_pkg::tgad_in_t item_s1,
	input  wire logic               adv,
	output tgad_pkg::tgad_res_t     res
);
	import tgad_pkg::*;

	typedef enum logic [3:0] {
		PH_HEADER = 4'b0001,
		PH_SKIP   = 4'b0010,
		PH_PIXELS = 4'b0100,
		PH_DONE   = 4'b1000
	} phase_t;

	phase_t            phase_q, phase_d, eff_phase;
	logic [HCNT_W-1:0] hcnt_q, hcnt_d, eff_hcnt;
	logic [7:0]        id_skip_q, id_skip_d;
	logic [7:0]        img_type_q, img_type_d;
	logic [15:0]       width_q, width_d;
	logic [15:0]       height_q, height_d;
	logic              four_q, four_d;
	logic              flip_q, flip_d;
	logic [1:0]        bip_q, bip_d, eff_bip;
	logic [23:0]       partial_q, partial_d, eff_partial;
	logic [15:0]       col_q, col_d, eff_col;
	logic [15:0]       row_q, row_d, eff_row;
	logic              take;
	logic [7:0]        b;
	logic [1:0]        last_idx;
	logic              col_end, row_end;

	assign take = valid_s1 && adv;
	assign b    = item_s1.file_byte;

	always_comb begin
		eff_phase   = phase_q;
		eff_hcnt    = hcnt_q;
		eff_bip     = bip_q;
		eff_partial = partial_q;
		eff_col     = col_q;
		eff_row     = row_q;
		if (item_s1.start_of_file) begin
			eff_phase   = PH_HEADER;
			eff_hcnt    = '0;
			eff_bip     = '0;
			eff_partial = '0;
			eff_col     = '0;
			eff_row     = '0;
		end

		phase_d    = eff_phase;
		hcnt_d     = eff_hcnt;
		id_skip_d  = id_skip_q;
		img_type_d = img_type_q;
		width_d    = width_q;
		height_d   = height_q;
		four_d     = four_q;
		flip_d     = flip_q;
		bip_d      = eff_bip;
		partial_d  = eff_partial;
		col_d      = eff_col;
		row_d      = eff_row;
		res        = '0;

		last_idx = four_q ? 2'd3 : 2'd2;
		col_end  = (eff_col == width_q - 16'd1);
		row_end  = (eff_row == height_q - 16'd1);

		unique case (eff_phase)
			PH_HEADER: begin
				hcnt_d = eff_hcnt + HCNT_W'(1);
				unique case (eff_hcnt)
					HDR_IDX_ID_LEN: id_skip_d = b;
					HDR_IDX_TYPE:   img_type_d = b;
					HDR_IDX_W_LO:   width_d = {width_q[15:8], b};
					HDR_IDX_W_HI:   width_d = {b, width_q[7:0]};
					HDR_IDX_H_LO:   height_d = {height_q[15:8], b};
					HDR_IDX_H_HI:   height_d = {b, height_q[7:0]};
					HDR_IDX_BPP: begin
						if ((img_type_q != TYPE_TRUECOLOUR && img_type_q != TYPE_GREY) ||
							(b != BPP_24 && b != BPP_32)) begin
							phase_d     = PH_DONE;
							res.valid   = 1'b1;
							res.item.status = ST_UNSUPPORTED;
						end else begin
							four_d = (b == BPP_32);
						end
					end
					HDR_IDX_DESC: begin
						flip_d    = !b[DESC_TOP_FIRST_BIT];
						bip_d     = '0;
						partial_d = '0;
						col_d     = '0;
						row_d     = '0;
						if (width_q == 16'd0 || height_q == 16'd0) begin
							phase_d     = PH_DONE;
							res.valid   = 1'b1;
							res.item.status = ST_EMPTY;
						end else begin
							phase_d = (id_skip_q != 8'd0) ? PH_SKIP : PH_PIXELS;
						end
					end
					default: ;
				endcase
			end
			PH_SKIP: begin
				id_skip_d = id_skip_q - 8'd1;
				if (id_skip_d == 8'd0) begin
					phase_d = PH_PIXELS;
				end
			end
			PH_PIXELS: begin
				if (eff_bip < last_idx) begin
					partial_d = eff_partial | ({16'd0, b} << {eff_bip, 3'b000});
					bip_d     = eff_bip + 2'd1;
				end else begin
					res.valid           = 1'b1;
					res.item.status     = ST_PIXEL;
					res.item.dest_row   = flip_q ? (height_q - 16'd1 - eff_row) : eff_row;
					res.item.dest_col   = eff_col;
					res.item.red        = four_q ? eff_partial[23:16] : b;
					res.item.green      = eff_partial[15:8];
					res.item.blue       = eff_partial[7:0];
					res.item.alpha      = four_q ? b : OPAQUE;
					res.item.last_pixel = col_end && row_end;
					bip_d     = '0;
					partial_d = '0;
					if (col_end && row_end) begin
						phase_d = PH_DONE;
					end else if (col_end) begin
						col_d = '0;
						row_d = eff_row + 16'd1;
					end else begin
						col_d = eff_col + 16'd1;
					end
				end
			end
			PH_DONE: ;
			default: phase_d = PH_HEADER;
		endcase

		res.valid = res.valid && valid_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			hcnt_q     <= '0;
			id_skip_q  <= '0;
			img_type_q <= '0;
			width_q    <= '0;
			height_q   <= '0;
			four_q     <= 1'b0;
			flip_q     <= 1'b0;
			bip_q      <= '0;
			partial_q  <= '0;
			col_q      <= '0;
			row_q      <= '0;
		end else if (take) begin
			phase_q    <= phase_d;
			hcnt_q     <= hcnt_d;
			id_skip_q  <= id_skip_d;
			img_type_q <= img_type_d;
			width_q    <= width_d;
			height_q   <= height_d;
			four_q     <= four_d;
			flip_q     <= flip_d;
			bip_q      <= bip_d;
			partial_q  <= partial_d;
			col_q      <= col_d;
			row_q      <= row_d;
		end
	end

	a_last_ends_image: assert property (@(posedge clk) disable iff (!arst_n)
		take && res.valid && res.item.status == ST_PIXEL && res.item.last_pixel
		|=> phase_q == PH_DONE)
		else $error("last pixel did not end the image");

	a_error_ends_image: assert property (@(posedge clk) disable iff (!arst_n)
		take && res.valid && res.item.status != ST_PIXEL |=> phase_q == PH_DONE)
		else $error("error status did not end the image");

	a_done_is_silent: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !item_s1.start_of_file && phase_q == PH_DONE |-> !res.valid)
		else $error("result produced after end of image");

	a_partial_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PIXELS |-> bip_q <= last_idx)
		else $error("pixel byte count overran");

endmodule

`default_nettype wire

/* design/tgad_out_reg.sv */
// ---------------------------------------------------------------------------
// tgad_out_reg
// Result register: holds a pixel or status item while the sink stalls.
// ---------------------------------------------------------------------------
`default_nettype none

module tgad_out_reg (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire tgad_pkg::tgad_res_t res,
	output logic                     adv,
	output logic                     res_valid,
	input  wire logic                res_stall,
	output tgad_pkg::tgad_out_t      res_item
);
	import tgad_pkg::*;

	assign adv = !res_valid || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (adv) begin
			res_valid <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.valid) begin
			res_item <= res.item;
		end
	end

endmodule

`default_nettype wire

/* design/tga_uncompressed_decoder.sv */
// ---------------------------------------------------------------------------
// tga_uncompressed_decoder
// A result passes from the input register through the parser into the result register.
// Throughput: one file byte per cycle, set by the single-byte parse step.
// A stalled result register holds; bytes keep entering while it is free.
// Reset (arst_n low) puts the parser in the header phase at byte 0.
// ---------------------------------------------------------------------------
`default_nettype none

module tga_uncompressed_decoder (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                file_valid,
	output logic                     file_stall,
	input  wire tgad_pkg::tgad_in_t  file_item,
	output logic                     res_valid,
	input  wire logic                res_stall,
	output tgad_pkg::tgad_out_t      res_item
);
	import tgad_pkg::*;

	logic      adv;
	logic      valid_s1;
	tgad_in_t  item_s1;
	tgad_res_t res;

	tgad_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.file_valid (file_valid),
		.file_stall (file_stall),
		.file_item  (file_item),
		.adv        (adv),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	tgad_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.adv      (adv),
		.res      (res)
	);

	tgad_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.adv       (adv),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

endmodule

`default_nettype wire

/* test/tga_uncompressed_decoder_tb.sv */
// ---------------------------------------------------------------------------
// tga_uncompressed_decoder_tb
// Streams TGA files into the decoder one byte per item and checks every
// pixel or status item against a cycle-free predictor of the header and
// pixel parse. Covers a first file with no start mark, unsupported
// formats, empty images, restarts in the header and in the pixel data, a
// long ID field, a long output hold-off and random files with random gaps.
// ---------------------------------------------------------------------------
module tga_uncompressed_decoder_tb;
	import tgad_pkg::*;

	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned HOLD_CYCLES = 400;

	typedef enum logic [1:0] {PH_HEADER, PH_SKIP, PH_PIXELS, PH_DONE} parse_phase_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      file_valid = 1'b0;
	logic      file_stall;
	tgad_in_t  file_item = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	tgad_out_t res_item;

	tgad_out_t   pixels_due[$];
	int unsigned mismatches = 0;
	int unsigned bytes_sent = 0;
	int unsigned quiet_cycles = 0;
	bit          tx_gaps = 1'b1;
	bit          rx_gaps = 1'b1;
	int unsigned hold_req = 0;
	int unsigned hold_served = 0;
	int unsigned hold_left = 0;
	int unsigned rx_burst = 0;

	parse_phase_t phase = PH_HEADER;
	logic [4:0]   hdr_idx = '0;
	logic [7:0]   id_left = '0;
	logic [7:0]   img_type = '0;
	logic [15:0]  img_w = '0;
	logic [15:0]  img_h = '0;
	logic         four_bpp = 1'b0;
	logic         flip = 1'b0;
	logic [1:0]   byte_idx = '0;
	logic [23:0]  part = '0;
	logic [15:0]  col = '0;
	logic [15:0]  row = '0;

	tga_uncompressed_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.file_valid(file_valid),
		.file_stall(file_stall),
		.file_item (file_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic bit decode_byte(input tgad_in_t it, output tgad_out_t res);
		logic [7:0]  b;
		logic [4:0]  idx;
		logic [23:0] px;
		logic [7:0]  alpha;
		logic        is_last;
		b = it.file_byte;
		res = '0;
		if (it.start_of_file) begin
			phase = PH_HEADER;
			hdr_idx = '0;
			byte_idx = '0;
			part = '0;
			col = '0;
			row = '0;
		end
		case (phase)
		PH_HEADER: begin
			idx = hdr_idx;
			hdr_idx = hdr_idx + 5'd1;
			case (idx)
			HDR_IDX_ID_LEN: id_left = b;
			HDR_IDX_TYPE: img_type = b;
			HDR_IDX_W_LO: img_w[7:0] = b;
			HDR_IDX_W_HI: img_w[15:8] = b;
			HDR_IDX_H_LO: img_h[7:0] = b;
			HDR_IDX_H_HI: img_h[15:8] = b;
			HDR_IDX_BPP: begin
				if ((img_type != TYPE_TRUECOLOUR && img_type != TYPE_GREY) ||
						(b != BPP_24 && b != BPP_32)) begin
					phase = PH_DONE;
					res.status = ST_UNSUPPORTED;
					return 1'b1;
				end
				four_bpp = (b == BPP_32);
			end
			HDR_IDX_DESC: begin
				flip = !b[DESC_TOP_FIRST_BIT];
				byte_idx = '0;
				part = '0;
				col = '0;
				row = '0;
				if (img_w == 16'd0 || img_h == 16'd0) begin
					phase = PH_DONE;
					res.status = ST_EMPTY;
					return 1'b1;
				end
				phase = (id_left != 8'd0) ? PH_SKIP : PH_PIXELS;
			end
			default: ;
			endcase
			return 1'b0;
		end
		PH_SKIP: begin
			id_left = id_left - 8'd1;
			if (id_left == 8'd0)
				phase = PH_PIXELS;
			return 1'b0;
		end
		PH_PIXELS: begin
			if (byte_idx < (four_bpp ? 2'd3 : 2'd2)) begin
				part = part | (24'(b) << (8 * byte_idx));
				byte_idx = byte_idx + 2'd1;
				return 1'b0;
			end
			px = part;
			if (four_bpp) begin
				alpha = b;
			end else begin
				px[23:16] = b;
				alpha = OPAQUE;
			end
			is_last = (col == img_w - 16'd1) && (row == img_h - 16'd1);
			res.status = ST_PIXEL;
			res.dest_row = flip ? img_h - 16'd1 - row : row;
			res.dest_col = col;
			res.red = px[23:16];
			res.green = px[15:8];
			res.blue = px[7:0];
			res.alpha = alpha;
			res.last_pixel = is_last;
			byte_idx = '0;
			part = '0;
			if (is_last) begin
				phase = PH_DONE;
			end else if (col == img_w - 16'd1) begin
				col = '0;
				row = row + 16'd1;
			end else begin
				col = col + 16'd1;
			end
			return 1'b1;
		end
		default: return 1'b0;
		endcase
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 2);
		if (r < 93)
			return $urandom_range(3, 6);
		return $urandom_range(10, 40);
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		mismatches++;
		if (mismatches <= 40)
			$display("%0t: %s got %0h want %0h", $time, what, got, want);
	endtask

	always @(posedge clk) begin : predict
		tgad_out_t px;
		if (file_valid && !file_stall) begin
			if (decode_byte(file_item, px))
				pixels_due.push_back(px);
		end
	end

	always @(posedge clk) begin : check
		tgad_out_t want;
		if (res_valid && !res_stall) begin
			if (pixels_due.size() == 0) begin
				report_mismatch("item with none expected, status", res_item.status, '0);
			end else begin
				want = pixels_due.pop_front();
				if (res_item.status !== want.status)
					report_mismatch("status", res_item.status, want.status);
				if (res_item.dest_row !== want.dest_row)
					report_mismatch("dest_row", res_item.dest_row, want.dest_row);
				if (res_item.dest_col !== want.dest_col)
					report_mismatch("dest_col", res_item.dest_col, want.dest_col);
				if (res_item.red !== want.red)
					report_mismatch("red", res_item.red, want.red);
				if (res_item.green !== want.green)
					report_mismatch("green", res_item.green, want.green);
				if (res_item.blue !== want.blue)
					report_mismatch("blue", res_item.blue, want.blue);
				if (res_item.alpha !== want.alpha)
					report_mismatch("alpha", res_item.alpha, want.alpha);
				if (res_item.last_pixel !== want.last_pixel)
					report_mismatch("last_pixel", res_item.last_pixel, want.last_pixel);
			end
		end
	end

	always @(posedge clk) begin
		if (hold_req != hold_served) begin
			hold_served <= hold_req;
			hold_left <= HOLD_CYCLES - 1;
			res_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			res_stall <= 1'b1;
		end else if (rx_burst != 0) begin
			rx_burst <= rx_burst - 1;
			res_stall <= 1'b1;
		end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
			rx_burst <= pick_gap() - 1;
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((file_valid && !file_stall) || (res_valid && !res_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_byte(input logic [7:0] b, input bit mark);
		int unsigned gap;
		file_valid <= 1'b1;
		file_item <= '{file_byte: b, start_of_file: mark};
		do @(posedge clk); while (file_stall);
		bytes_sent++;
		gap = (tx_gaps && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
		if (gap != 0) begin
			file_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_file(input bit mark, input logic [7:0] id_len,
			input logic [7:0] ftype, input logic [15:0] w, input logic [15:0] h,
			input logic [7:0] bpp, input logic [7:0] desc,
			input int unsigned hdr_bytes, input int unsigned data_bytes);
		logic [7:0] b;
		for (int unsigned i = 0; i < hdr_bytes; i++) begin
			case (5'(i))
			HDR_IDX_ID_LEN: b = id_len;
			HDR_IDX_TYPE: b = ftype;
			HDR_IDX_W_LO: b = w[7:0];
			HDR_IDX_W_HI: b = w[15:8];
			HDR_IDX_H_LO: b = h[7:0];
			HDR_IDX_H_HI: b = h[15:8];
			HDR_IDX_BPP: b = bpp;
			HDR_IDX_DESC: b = desc;
			default: b = 8'($urandom);
			endcase
			send_byte(b, mark && i == 0);
		end
		for (int unsigned i = 0; i < data_bytes; i++) begin
			case ($urandom_range(0, 7))
			0: b = 8'h00;
			1: b = 8'hFF;
			default: b = 8'($urandom);
			endcase
			send_byte(b, 1'b0);
		end
	endtask

	task automatic wait_drained();
		file_valid <= 1'b0;
		@(posedge clk);
		while (pixels_due.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic test_no_start_mark();
		send_file(1'b0, 8'd0, TYPE_TRUECOLOUR, 16'd1, 16'd1, BPP_24, 8'h00, HDR_LEN, 5);
		wait_drained();
	endtask

	task automatic test_unsupported_format();
		send_file(1'b1, 8'd0, 8'd10, 16'd2, 16'd2, BPP_32, 8'h20, HDR_LEN, 4);
		send_file(1'b1, 8'd0, TYPE_GREY, 16'd1, 16'd1, 8'd31, 8'h00, HDR_LEN, 3);
		send_file(1'b1, 8'd0, 8'hFF, 16'd1, 16'd1, BPP_24, 8'h00, HDR_LEN, 0);
	endtask

	task automatic test_empty_image();
		send_file(1'b1, 8'd0, TYPE_TRUECOLOUR, 16'd0, 16'd3, BPP_24, 8'h00, HDR_LEN, 3);
		send_file(1'b1, 8'd5, TYPE_GREY, 16'h0100, 16'd0, BPP_32, 8'h20, HDR_LEN, 2);
	endtask

	task automatic test_restart_mid_file();
		send_file(1'b1, 8'd0, TYPE_TRUECOLOUR, 16'hFFFF, 16'hFFFF, BPP_24, 8'h00, HDR_LEN, 7);
		send_file(1'b1, 8'd0, TYPE_GREY, 16'd2, 16'd2, BPP_32, 8'h00, 9, 0);
		send_file(1'b1, 8'd2, TYPE_TRUECOLOUR, 16'd2, 16'd2, BPP_32, 8'h20, HDR_LEN, 19);
		wait_drained();
	endtask

	task automatic test_long_id_field();
		send_file(1'b1, 8'hFF, TYPE_GREY, 16'd3, 16'd1, BPP_24, 8'hDF, HDR_LEN, 255 + 9);
		wait_drained();
	endtask

	task automatic test_output_hold_off();
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		hold_req++;
		send_file(1'b1, 8'd0, TYPE_TRUECOLOUR, 16'd8, 16'd8, BPP_24, 8'h00, HDR_LEN, 192);
		wait_drained();
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
	endtask

	task automatic test_random_files();
		int unsigned     first;
		logic [7:0]      id_len;
		logic [7:0]      ftype;
		logic [7:0]      bpp;
		logic [15:0]     w;
		logic [15:0]     h;
		longint unsigned full;
		int unsigned     data;
		first = bytes_sent;
		while (bytes_sent - first < 1000) begin
			tx_gaps = $urandom_range(0, 3) != 0;
			rx_gaps = $urandom_range(0, 3) != 0;
			id_len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(4, 30))
				: 8'($urandom_range(0, 2));
			ftype = ($urandom_range(0, 9) == 0) ? 8'($urandom)
				: ($urandom_range(0, 1) ? TYPE_TRUECOLOUR : TYPE_GREY);
			bpp = ($urandom_range(0, 9) == 0) ? 8'($urandom)
				: ($urandom_range(0, 1) ? BPP_32 : BPP_24);
			w = 16'($urandom_range(1, ($urandom_range(0, 7) == 0) ? 12 : 4));
			h = 16'($urandom_range(1, ($urandom_range(0, 7) == 0) ? 12 : 4));
			case ($urandom_range(0, 19))
			0: w = 16'd0;
			1: h = 16'd0;
			2: w = 16'($urandom);
			3: h = 16'($urandom);
			default: ;
			endcase
			full = id_len + longint'(w) * h * ((bpp == BPP_32) ? 4 : 3);
			if (full > 200)
				data = $urandom_range(0, 60);
			else if ($urandom_range(0, 9) == 0)
				data = $urandom_range(0, int'(full));
			else
				data = int'(full) + $urandom_range(0, 3);
			send_file($urandom_range(0, 19) != 0, id_len, ftype, w, h, bpp, 8'($urandom),
				($urandom_range(0, 29) == 0) ? $urandom_range(1, HDR_LEN - 1) : HDR_LEN,
				data);
			if ($urandom_range(0, 9) == 0)
				wait_drained();
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_no_start_mark();
		test_unsupported_format();
		test_empty_image();
		test_restart_mid_file();
		test_long_id_field();
		test_output_hold_off();
		test_random_files();
		wait_drained();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
